FILE: rtl/fr2m_pkg.sv
`default_nettype none

package fr2m_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ACT_W  = 2;
    localparam int STAT_W = 2;
    localparam int QCNT_W = 5;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_ROTATE = 2'd2
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic              push;
        logic              shift;
        logic              rot;
        logic [DATA_W-1:0] push_data;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: rtl/fr2m_if.sv
`default_nettype none

interface fr2m_in_if;
    logic                        valid;
    logic                        ready;
    logic [fr2m_pkg::ACT_W-1:0]  action;
    logic signed [fr2m_pkg::DATA_W-1:0] value_in;

    modport source (output valid, output action, output value_in, input ready);
    modport sink   (input valid, input action, input value_in, output ready);
endinterface

interface fr2m_out_if;
    logic                        valid;
    logic                        ready;
    logic signed [fr2m_pkg::DATA_W-1:0] value_out;
    logic [fr2m_pkg::STAT_W-1:0] status;
    logic [fr2m_pkg::QCNT_W-1:0] queue_count;

    modport source (output valid, output value_out, output status, output queue_count,
                    input ready);
    modport sink   (input valid, input value_out, input status, input queue_count,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/fr2m_cell.sv
`default_nettype none

module fr2m_cell (
    input  wire logic                        i_clk,
    input  wire fr2m_pkg::t_cell_ctl         i_ctl,
    input  wire logic                        i_push_sel,
    input  wire logic                        i_wrap_sel,
    input  wire logic [fr2m_pkg::DATA_W-1:0] i_next,
    input  wire logic [fr2m_pkg::DATA_W-1:0] i_head,
    output logic      [fr2m_pkg::DATA_W-1:0] o_data
);

    logic [fr2m_pkg::DATA_W-1:0] r_data;
    logic [fr2m_pkg::DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.push && i_push_sel) begin
            n_data = i_ctl.push_data;
        end else if (i_ctl.shift) begin
            // last occupied slot takes the old head on a rotate step
            n_data = (i_ctl.rot && i_wrap_sel) ? i_head : i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

FILE: rtl/fifo_rotate_to_max_unit.sv
`default_nettype none

// channel   dir  modport  payload
// i_req     in   sink     action[1:0], value_in[31:0] signed q16.16
// o_rsp     out  source   value_out[31:0] signed, status[1:0], queue_count[4:0]
//
// push, pop and unused action codes: result registered at accept
// rotate: a scan over every occupied entry, then up to count-1 move steps, one shift of the
//   cell chain per cycle, before the result is loaded
// reset clears fill count, state and output valid; cell data is not reset
// a new transaction is taken only in idle with the output register free or draining
// a stalled output holds a finished rotate in its last state until the slot frees

module fifo_rotate_to_max_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    fr2m_in_if.sink          i_req,
    fr2m_out_if.source       o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_MOVE = 3'b100
    } t_state;

    localparam int DW = fr2m_pkg::DATA_W;
    localparam int CW = fr2m_pkg::CNT_W;
    localparam int IW = fr2m_pkg::IDX_W;

    // cell chain, cell 0 always holds the head entry
    logic [DW-1:0]        w_cell   [fr2m_pkg::DEPTH];
    logic [DW-1:0]        w_next   [fr2m_pkg::DEPTH];
    fr2m_pkg::t_cell_ctl  w_ctl;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [IW-1:0]        r_k, n_k;
    logic [IW-1:0]        r_steps, n_steps;
    logic [DW-1:0]        r_best, n_best;

    logic                 r_out_valid, n_out_valid;
    logic [DW-1:0]        r_value_out, n_value_out;
    fr2m_pkg::t_status    r_status, n_status;
    logic [CW-1:0]        r_count_out, n_count_out;

    logic                 w_slot_free;
    logic                 w_accept;
    logic                 w_greater;
    logic [CW-1:0]        w_last;

    assign w_slot_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && w_slot_free;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_greater   = $signed(w_cell[0]) > $signed(r_best);
    assign w_last      = r_count - CW'(1);

    genvar gi;
    generate
        for (gi = 0; gi < fr2m_pkg::DEPTH; gi++) begin : g_cell
            if (gi == fr2m_pkg::DEPTH - 1) begin : g_end
                assign w_next[gi] = '0;
            end else begin : g_mid
                assign w_next[gi] = w_cell[gi+1];
            end

            fr2m_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_push_sel (r_count == CW'(gi)),
                .i_wrap_sel (w_last == CW'(gi)),
                .i_next     (w_next[gi]),
                .i_head     (w_cell[0]),
                .o_data     (w_cell[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_k         = r_k;
        n_steps     = r_steps;
        n_best      = r_best;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_value_out = r_value_out;
        n_status    = r_status;
        n_count_out = r_count_out;

        w_ctl.push      = 1'b0;
        w_ctl.shift     = 1'b0;
        w_ctl.rot       = 1'b0;
        w_ctl.push_data = i_req.value_in;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_value_out = '0;
                    n_status    = fr2m_pkg::STAT_OK;
                    n_count_out = r_count;
                    case (fr2m_pkg::t_action'(i_req.action))
                        fr2m_pkg::ACT_PUSH: begin
                            if (r_count >= CW'(fr2m_pkg::DEPTH)) begin
                                n_status = fr2m_pkg::STAT_FULL;
                            end else begin
                                w_ctl.push  = 1'b1;
                                n_count     = r_count + CW'(1);
                                n_count_out = n_count;
                            end
                        end
                        fr2m_pkg::ACT_POP: begin
                            if (r_count == '0) begin
                                n_status = fr2m_pkg::STAT_EMPTY;
                            end else begin
                                w_ctl.shift = 1'b1;
                                n_value_out = w_cell[0];
                                n_count     = w_last;
                                n_count_out = w_last;
                            end
                        end
                        fr2m_pkg::ACT_ROTATE: begin
                            if (r_count == '0) begin
                                n_status = fr2m_pkg::STAT_EMPTY;
                            end else begin
                                // result comes at the end of the walk
                                n_out_valid = r_out_valid && !o_rsp.ready;
                                n_state     = S_SCAN;
                                n_k         = '0;
                                n_steps     = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // full turn of the ring, head entry seen once per cycle
                w_ctl.shift = 1'b1;
                w_ctl.rot   = 1'b1;
                if ((r_k == '0) || w_greater) begin
                    n_best  = w_cell[0];
                    n_steps = r_k;
                end
                if (CW'(r_k) == w_last) begin
                    n_state = S_MOVE;
                    n_k     = '0;
                end else begin
                    n_k = r_k + IW'(1);
                end
            end
            S_MOVE: begin
                if (r_k == r_steps) begin
                    if (w_slot_free) begin
                        n_out_valid = 1'b1;
                        n_value_out = '0;
                        n_status    = fr2m_pkg::STAT_OK;
                        n_count_out = r_count;
                        n_state     = S_IDLE;
                    end
                end else begin
                    w_ctl.shift = 1'b1;
                    w_ctl.rot   = 1'b1;
                    n_k         = r_k + IW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and walk registers carry no reset
    always_ff @(posedge i_clk) begin
        r_k         <= n_k;
        r_steps     <= n_steps;
        r_best      <= n_best;
        r_value_out <= n_value_out;
        r_status    <= n_status;
        r_count_out <= n_count_out;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.value_out   = r_value_out;
    assign o_rsp.status      = r_status;
    assign o_rsp.queue_count = fr2m_pkg::QCNT_W'(r_count_out);

    // fill count stays within the ring
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(fr2m_pkg::DEPTH))
        else $error("fill count beyond depth");

    // a rotate walk never changes the fill count
    a_walk_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> $stable(r_count))
        else $error("fill count moved during rotate");

    // accepted push with room grows the queue by one
    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.action == fr2m_pkg::ACT_PUSH)
            && (r_count < CW'(fr2m_pkg::DEPTH)))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow queue");

    // every accepted transaction outside rotate leaves a result at once
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.action != fr2m_pkg::ACT_ROTATE)) |=> r_out_valid)
        else $error("missing result after transaction");

endmodule

`default_nettype wire
